### sv/lmpc_pkg.sv
// ----------------------------------------------------------------------------
// lmpc_pkg
// Shared types and constants for the lamp mode and PWM duty controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lmpc_pkg;

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_RAMP_TOP        = 3'd0,
        REG_RAMP_BOTTOM     = 3'd1,
        REG_STEP_MS         = 3'd2,
        REG_BOTTOM_HOLD_MS  = 3'd3,
        REG_STROBE_HALF_MS  = 3'd4,
        REG_PRESS_WINDOW_MS = 3'd5,
        REG_HALF_LEVEL      = 3'd6,
        REG_TENTH_LEVEL     = 3'd7
    } reg_idx_t;

    // Reset values of the configuration registers
    localparam logic [7:0] RampTopRst       = 8'd170;
    localparam logic [7:0] RampBottomRst    = 8'd1;
    localparam logic [7:0] StepMsRst        = 8'd5;
    localparam logic [7:0] BottomHoldMsRst  = 8'd150;
    localparam logic [7:0] StrobeHalfMsRst  = 8'd100;
    localparam logic [7:0] PressWindowMsRst = 8'd200;
    localparam logic [7:0] HalfLevelRst     = 8'd50;
    localparam logic [7:0] TenthLevelRst    = 8'd10;

    localparam logic [7:0] DutyFull = 8'd255;
    localparam logic [7:0] DutyOff  = 8'd0;

    typedef enum logic [2:0] {
        MODE_PULSE  = 3'd0,
        MODE_FULL   = 3'd1,
        MODE_HALF   = 3'd2,
        MODE_TENTH  = 3'd3,
        MODE_STROBE = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WINDOW = 2'd1,
        PH_HOLD   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] ramp_top;
        logic [7:0] ramp_bottom;
        logic [7:0] step_ms;
        logic [7:0] bottom_hold_ms;
        logic [7:0] strobe_half_ms;
        logic [7:0] press_window_ms;
        logic [7:0] half_level;
        logic [7:0] tenth_level;
    } cfg_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] level;
        logic       ramping_down;
        logic [8:0] ms_count;
        phase_t     phase;
        logic [7:0] press_count;
        logic [8:0] strobe_count;
    } state_t;

    typedef struct packed {
        logic [7:0] duty;
        mode_t      lamp_mode;
        logic       hold_strobing;
    } result_t;

endpackage : lmpc_pkg

`default_nettype wire

### sv/lmpc_step.sv
// ----------------------------------------------------------------------------
// lmpc_step
// One millisecond tick of the controller: press handling, long-press strobe
// overlay and the mode pattern, computed as next state plus one result.
// ----------------------------------------------------------------------------
`default_nettype none

module lmpc_step (
    input  var lmpc_pkg::state_t  state_cur,
    input  var lmpc_pkg::cfg_t    cfg,
    input  wire logic             button_pressed,
    output lmpc_pkg::state_t      state_next,
    output lmpc_pkg::result_t     result
);

    // Restart the pattern of the mode held in s
    function automatic lmpc_pkg::state_t restart_pattern(input lmpc_pkg::state_t s,
                                                         input lmpc_pkg::cfg_t c);
        lmpc_pkg::state_t r;
        r              = s;
        r.ms_count     = '0;
        r.ramping_down = 1'b0;
        case (s.mode)
            lmpc_pkg::MODE_PULSE: r.level = c.ramp_bottom;
            lmpc_pkg::MODE_HALF:  r.level = c.half_level;
            lmpc_pkg::MODE_TENTH: r.level = c.tenth_level;
            default:              r.level = lmpc_pkg::DutyFull;
        endcase
        return r;
    endfunction

    // Step to the next mode in the ring
    function automatic lmpc_pkg::mode_t advance_mode(input lmpc_pkg::mode_t m);
        lmpc_pkg::mode_t r;
        case (m)
            lmpc_pkg::MODE_PULSE: r = lmpc_pkg::MODE_FULL;
            lmpc_pkg::MODE_FULL:  r = lmpc_pkg::MODE_HALF;
            lmpc_pkg::MODE_HALF:  r = lmpc_pkg::MODE_TENTH;
            lmpc_pkg::MODE_TENTH: r = lmpc_pkg::MODE_STROBE;
            default:              r = lmpc_pkg::MODE_PULSE;
        endcase
        return r;
    endfunction

    always_comb
    begin
        lmpc_pkg::state_t s;
        logic [7:0] duty_v;
        logic       strobing_v;
        logic [7:0] pc_inc;
        logic [8:0] sc_inc;
        logic [8:0] ms_inc;
        logic [8:0] two_half;
        logic [8:0] hold_v;
        logic [7:0] lvl;

        s          = state_cur;
        duty_v     = s.level;
        strobing_v = 1'b0;
        two_half   = {cfg.strobe_half_ms, 1'b0};
        lvl        = '0;
        hold_v     = '0;
        ms_inc     = '0;
        sc_inc     = '0;

        // Close the press window once it has run its length
        pc_inc = s.press_count + 8'd1;
        if (s.phase == lmpc_pkg::PH_WINDOW)
        begin
            s.press_count = pc_inc;
            if (pc_inc >= cfg.press_window_ms)
            begin
                if (button_pressed)
                begin
                    s.phase        = lmpc_pkg::PH_HOLD;
                    s.strobe_count = '0;
                end
                else
                begin
                    s.phase = lmpc_pkg::PH_IDLE;
                    s.mode  = advance_mode(s.mode);
                    s       = restart_pattern(s, cfg);
                end
            end
        end

        case (s.phase)
            // Freeze the output during the window
            lmpc_pkg::PH_WINDOW:
            begin
                duty_v = s.level;
            end

            // Run the long-press strobe in whole cycles
            lmpc_pkg::PH_HOLD:
            begin
                strobing_v = 1'b1;
                duty_v     = ({1'b0, cfg.strobe_half_ms} > s.strobe_count)
                             ? lmpc_pkg::DutyFull : lmpc_pkg::DutyOff;
                sc_inc     = s.strobe_count + 9'd1;
                s.strobe_count = sc_inc;
                if (sc_inc >= two_half)
                begin
                    s.strobe_count = '0;
                    if (!button_pressed)
                    begin
                        s.phase = lmpc_pkg::PH_IDLE;
                        s       = restart_pattern(s, cfg);
                    end
                end
            end

            default:
            begin
                if (button_pressed)
                begin
                    // Enter the press window
                    s.phase       = lmpc_pkg::PH_WINDOW;
                    s.press_count = '0;
                    duty_v        = s.level;
                end
                else
                begin
                    s.phase = lmpc_pkg::PH_IDLE;
                    ms_inc  = s.ms_count + 9'd1;
                    case (s.mode)
                        // Breathing ramp with a pause at the bottom
                        lmpc_pkg::MODE_PULSE:
                        begin
                            lvl = s.level;
                            if (!s.ramping_down && (lvl < cfg.ramp_bottom))
                                lvl = cfg.ramp_bottom;
                            duty_v = lvl;
                            hold_v = {1'b0, cfg.step_ms};
                            if (s.ramping_down && (lvl <= cfg.ramp_bottom))
                                hold_v = hold_v + {1'b0, cfg.bottom_hold_ms};
                            s.ms_count = ms_inc;
                            if (ms_inc >= hold_v)
                            begin
                                s.ms_count = '0;
                                if (!s.ramping_down)
                                begin
                                    if (lvl >= cfg.ramp_top)
                                    begin
                                        s.ramping_down = 1'b1;
                                        if (lvl > cfg.ramp_bottom)
                                            lvl = lvl - 8'd1;
                                    end
                                    else
                                    begin
                                        lvl = lvl + 8'd1;
                                    end
                                end
                                else if (lvl > cfg.ramp_bottom)
                                begin
                                    lvl = lvl - 8'd1;
                                end
                                else
                                begin
                                    s.ramping_down = 1'b0;
                                end
                            end
                            s.level = lvl;
                        end

                        // Square wave of two equal phases
                        lmpc_pkg::MODE_STROBE:
                        begin
                            duty_v = ({1'b0, cfg.strobe_half_ms} > s.ms_count)
                                     ? lmpc_pkg::DutyFull : lmpc_pkg::DutyOff;
                            s.level    = duty_v;
                            s.ms_count = ms_inc;
                            if (ms_inc >= two_half)
                                s.ms_count = '0;
                        end

                        lmpc_pkg::MODE_FULL:
                        begin
                            duty_v  = lmpc_pkg::DutyFull;
                            s.level = duty_v;
                        end

                        lmpc_pkg::MODE_HALF:
                        begin
                            duty_v  = cfg.half_level;
                            s.level = duty_v;
                        end

                        lmpc_pkg::MODE_TENTH:
                        begin
                            duty_v  = cfg.tenth_level;
                            s.level = duty_v;
                        end

                        default:
                        begin
                            duty_v = s.level;
                        end
                    endcase
                end
            end
        endcase

        state_next           = s;
        result.duty          = duty_v;
        result.lamp_mode     = s.mode;
        result.hold_strobing = strobing_v;
    end

endmodule : lmpc_step

`default_nettype wire

### sv/led_lamp_mode_pwm_controller_unit.sv
// ----------------------------------------------------------------------------
// led_lamp_mode_pwm_controller_unit
// Lamp mode and PWM duty controller advanced once per 1 ms tick transaction.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   -----------------------------------
//   in        in_valid/in_ready    button_pressed
//   out       out_valid/out_ready  duty, lamp_mode, hold_strobing
//   cfg       cfg_valid/cfg_ready  cfg_index (3b), cfg_data (8b)
//
// One tick transaction is taken per cycle while in_ready is high; its result
// is registered in the output register, or in the skid register while one
// waits there. All state updates pass through the tick logic. The two
// registers let one more tick be accepted while a result waits; in_ready
// drops only when both are full. Reset puts the configuration registers at
// their defaults, pulse mode, idle. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module led_lamp_mode_pwm_controller_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       button_pressed,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      duty,
    output logic [2:0]      lamp_mode,
    output logic            hold_strobing,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    lmpc_pkg::cfg_t    cfg_reg;
    lmpc_pkg::state_t  state_reg;
    lmpc_pkg::state_t  state_next;
    lmpc_pkg::result_t tick_result;

    logic              out_valid_reg;
    logic              out_valid_next;
    lmpc_pkg::result_t out_data_reg;
    lmpc_pkg::result_t out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    lmpc_pkg::result_t skid_data_reg;
    lmpc_pkg::result_t skid_data_next;

    logic              in_accept;
    logic              out_accept;

    assign cfg_ready  = 1'b1;
    assign in_ready   = !skid_valid_reg;
    assign in_accept  = in_valid && in_ready;
    assign out_accept = out_valid_reg && out_ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ramp_top        <= lmpc_pkg::RampTopRst;
            cfg_reg.ramp_bottom     <= lmpc_pkg::RampBottomRst;
            cfg_reg.step_ms         <= lmpc_pkg::StepMsRst;
            cfg_reg.bottom_hold_ms  <= lmpc_pkg::BottomHoldMsRst;
            cfg_reg.strobe_half_ms  <= lmpc_pkg::StrobeHalfMsRst;
            cfg_reg.press_window_ms <= lmpc_pkg::PressWindowMsRst;
            cfg_reg.half_level      <= lmpc_pkg::HalfLevelRst;
            cfg_reg.tenth_level     <= lmpc_pkg::TenthLevelRst;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lmpc_pkg::reg_idx_t'(cfg_index))
                lmpc_pkg::REG_RAMP_TOP:        cfg_reg.ramp_top        <= cfg_data;
                lmpc_pkg::REG_RAMP_BOTTOM:     cfg_reg.ramp_bottom     <= cfg_data;
                lmpc_pkg::REG_STEP_MS:         cfg_reg.step_ms         <= cfg_data;
                lmpc_pkg::REG_BOTTOM_HOLD_MS:  cfg_reg.bottom_hold_ms  <= cfg_data;
                lmpc_pkg::REG_STROBE_HALF_MS:  cfg_reg.strobe_half_ms  <= cfg_data;
                lmpc_pkg::REG_PRESS_WINDOW_MS: cfg_reg.press_window_ms <= cfg_data;
                lmpc_pkg::REG_HALF_LEVEL:      cfg_reg.half_level      <= cfg_data;
                lmpc_pkg::REG_TENTH_LEVEL:     cfg_reg.tenth_level     <= cfg_data;
                default:                       cfg_reg.ramp_top        <= cfg_reg.ramp_top;
            endcase
        end
    end

    // Tick logic
    lmpc_step u_step (
        .state_cur      (state_reg),
        .cfg            (cfg_reg),
        .button_pressed (button_pressed),
        .state_next     (state_next),
        .result         (tick_result)
    );

    // Advance state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode         <= lmpc_pkg::MODE_PULSE;
            state_reg.level        <= '0;
            state_reg.ramping_down <= 1'b0;
            state_reg.ms_count     <= '0;
            state_reg.phase        <= lmpc_pkg::PH_IDLE;
            state_reg.press_count  <= '0;
            state_reg.strobe_count <= '0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Route results through output and skid registers
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_accept)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_accept)
            begin
                out_data_next = tick_result;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg)
        begin
            if (in_accept)
            begin
                out_valid_next = 1'b1;
                out_data_next  = tick_result;
            end
        end
        else if (in_accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = tick_result;
        end
    end

    // Hold handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold result payloads
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid     = out_valid_reg;
    assign duty          = out_data_reg.duty;
    assign lamp_mode     = out_data_reg.lamp_mode;
    assign hold_strobing = out_data_reg.hold_strobing;

endmodule : led_lamp_mode_pwm_controller_unit

`default_nettype wire
